// File: rtl/lvv_pkg.sv
`default_nettype none
package lvv_pkg;

  // Configuration port geometry and register indexes.
  localparam int CFG_W = 11;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET = 11'd640;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 11'd480;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Field widths of the result word.
  localparam int VAR_W = 23;
  localparam int POS_W = 10;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } in_word_t;

  typedef struct packed {
    logic [VAR_W-1:0] variance;
    logic [POS_W-1:0] center_row;
    logic [POS_W-1:0] center_col;
    logic             frame_end;
  } out_word_t;

  // Position data that travels alongside a window.
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             frame_end;
  } meta_t;

  // One classified window handed from front to back.
  typedef struct packed {
    logic [8:0][7:0] win;
    meta_t           meta;
  } job_t;

  typedef enum logic {
    FS_IDLE,
    FS_UPDATE
  } front_state_t;

endpackage
`default_nettype wire

// File: rtl/lvv_stream_if.sv
`default_nettype none
interface lvv_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/lbp_var_local_variance_3x3.sv
`default_nettype none
// Local variance of the radius-1, 8-point circle over a raster stream of 8-bit grey
// pixels. A pixel is accepted in FS_IDLE and finished in FS_UPDATE: its line-store
// entry is read in the accept cycle and rewritten in the next, so no new pixel is taken
// while one is finished or while the queue is full. A result for interior pixel (r,c)
// comes from the update of pixel (r+1,c+1) through a six-register arithmetic pipeline;
// a four-entry queue between them lets the pixel side keep going while results are
// held. Border pixels give no result. Size registers are written through cfg_we /
// cfg_index / cfg_data (index 0 width, index 1 height) and are clamped to 3..MAX. Line
// stores need no clearing after reset; a frame starts with frame_start or after reset.
module lbp_var_local_variance_3x3 #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  lvv_stream_if.sink                         in_s,
  lvv_stream_if.source                       out_s,
  input  wire logic                          cfg_we,
  input  wire logic [lvv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lvv_pkg::CFG_W-1:0]     cfg_data
);
  logic          q_full, q_empty, q_push, q_pop;
  lvv_pkg::job_t push_job, pop_job;

  // Front end: raster position, line stores and window.
  lvv_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk(clk), .rst_n(rst_n), .in_s(in_s),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_full(q_full), .q_push(q_push), .q_job(push_job)
  );

  // Queue of windows waiting for the arithmetic.
  lvv_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .push_job(push_job), .full(q_full),
    .pop(q_pop), .pop_job(pop_job), .empty(q_empty)
  );

  // Back end: samples, sums and the scaled variance.
  lvv_back #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .job(pop_job), .q_empty(q_empty), .q_pop(q_pop),
    .out_s(out_s)
  );
endmodule
`default_nettype wire

// File: rtl/lvv_ram.sv
`default_nettype none
module lvv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/lvv_front.sv
`default_nettype none
module lvv_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  lvv_stream_if.sink                         in_s,
  input  wire logic                          cfg_we,
  input  wire logic [lvv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lvv_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          q_full,
  output logic                               q_push,
  output lvv_pkg::job_t                      q_job
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int SW0 = (CW + 1 > lvv_pkg::CFG_W) ? CW + 1 : lvv_pkg::CFG_W;
  localparam int SW = (RW + 1 > SW0) ? RW + 1 : SW0;

  lvv_pkg::front_state_t state_r, state_nxt;
  logic [lvv_pkg::CFG_W-1:0] width_cfg_r, height_cfg_r;
  logic [CW-1:0] col_r, col_nxt, c_r;
  logic [RW-1:0] row_r, row_nxt, r_r;
  logic [7:0]    pix_r;
  logic [8:0][7:0] win_r, win_nxt;
  logic [SW-1:0] width_u, height_u, width_raw, height_raw;
  logic [CW-1:0] col_cur;
  logic [RW-1:0] row_cur;
  logic [SW-1:0] col_inc, row_inc, c_ext, r_ext, row_m1, col_m1;
  logic [7:0]    up1, up2;
  logic          accept, ram_we, hit;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= lvv_pkg::IMAGE_WIDTH_RESET;
      height_cfg_r <= lvv_pkg::IMAGE_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lvv_pkg::REG_IMAGE_WIDTH:  width_cfg_r  <= cfg_data;
        lvv_pkg::REG_IMAGE_HEIGHT: height_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame size clamped to the supported range.
  always_comb begin
    width_raw  = SW'(width_cfg_r);
    height_raw = SW'(height_cfg_r);
    if (width_raw < SW'(3)) width_u = SW'(3);
    else if (width_raw > SW'(MAX_WIDTH)) width_u = SW'(MAX_WIDTH);
    else width_u = width_raw;
    if (height_raw < SW'(3)) height_u = SW'(3);
    else if (height_raw > SW'(MAX_HEIGHT)) height_u = SW'(MAX_HEIGHT);
    else height_u = height_raw;
  end

  // Raster position of the arriving word and the position after it.
  always_comb begin
    col_cur = in_s.data.frame_start ? '0 : col_r;
    row_cur = in_s.data.frame_start ? '0 : row_r;
    col_inc = SW'(col_cur) + SW'(1);
    row_inc = SW'(row_cur) + SW'(1);
    if (col_inc >= width_u) begin
      col_nxt = '0;
      row_nxt = (row_inc >= height_u) ? '0 : row_inc[RW-1:0];
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = row_cur;
    end
  end

  // Line stores: read when a word is taken, rewritten on the next cycle.
  lvv_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line_one (
    .clk(clk), .we(ram_we), .waddr(c_r), .wdata(pix_r), .raddr(col_cur), .rdata(up1)
  );
  lvv_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line_two (
    .clk(clk), .we(ram_we), .waddr(c_r), .wdata(up1), .raddr(col_cur), .rdata(up2)
  );

  // Window shift and interior test for the word being finished.
  always_comb begin
    win_nxt = win_r;
    win_nxt[0] = win_r[1]; win_nxt[1] = win_r[2]; win_nxt[2] = up2;
    win_nxt[3] = win_r[4]; win_nxt[4] = win_r[5]; win_nxt[5] = up1;
    win_nxt[6] = win_r[7]; win_nxt[7] = win_r[8]; win_nxt[8] = pix_r;
    c_ext  = SW'(c_r);
    r_ext  = SW'(r_r);
    row_m1 = r_ext - SW'(1);
    col_m1 = c_ext - SW'(1);
    hit = (r_ext >= SW'(2)) && (c_ext >= SW'(2)) && (r_ext < height_u) && (c_ext < width_u);
    q_job.win = win_nxt;
    q_job.meta.row = row_m1[lvv_pkg::POS_W-1:0];
    q_job.meta.col = col_m1[lvv_pkg::POS_W-1:0];
    q_job.meta.frame_end = (r_ext == height_u - SW'(1)) && (c_ext == width_u - SW'(1));
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lvv_pkg::FS_IDLE:   if (in_s.valid && !q_full) state_nxt = lvv_pkg::FS_UPDATE;
      lvv_pkg::FS_UPDATE: state_nxt = lvv_pkg::FS_IDLE;
      default:            state_nxt = lvv_pkg::FS_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_s.ready = 1'b0;
    ram_we     = 1'b0;
    q_push     = 1'b0;
    unique case (state_r)
      lvv_pkg::FS_IDLE:   in_s.ready = !q_full;
      lvv_pkg::FS_UPDATE: begin
        ram_we = 1'b1;
        q_push = hit;
      end
      default: ;
    endcase
  end

  assign accept = in_s.valid && in_s.ready;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lvv_pkg::FS_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      win_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (ram_we) begin
        win_r <= win_nxt;
      end
    end
  end

  // Word held for the update cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      c_r   <= col_cur;
      r_r   <= row_cur;
      pix_r <= in_s.data.pixel;
    end
  end

`ifndef ASSERT_OFF
  a_update_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lvv_pkg::FS_UPDATE |-> $past(accept))
    else $error("update cycle without a preceding accept");
  a_no_accept_in_update: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !accept)
    else $error("two words accepted on consecutive cycles");
`endif
endmodule
`default_nettype wire

// File: rtl/lvv_queue.sv
`default_nettype none
module lvv_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  lvv_pkg::job_t      push_job,
  output logic               full,
  input  wire logic          pop,
  output lvv_pkg::job_t      pop_job,
  output logic               empty
);
  lvv_pkg::job_t entry_r [lvv_pkg::QUEUE_DEPTH];
  logic [lvv_pkg::QPTR_W-1:0] wptr_r, rptr_r;
  logic [lvv_pkg::QCNT_W-1:0] count_r;

  assign full    = (count_r == lvv_pkg::QCNT_W'(lvv_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = entry_r[rptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) entry_r[wptr_r] <= push_job;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue read while empty");
`endif
endmodule
`default_nettype wire

// File: rtl/lvv_back.sv
`default_nettype none
module lvv_back #(
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  lvv_pkg::job_t  job,
  input  wire logic      q_empty,
  output logic           q_pop,
  lvv_stream_if.source   out_s
);
  localparam int F  = WEIGHT_FRAC_BITS;
  localparam int XW = 8 + F;
  localparam int SUMW = XW + 3;
  localparam int SQW = 2 * XW;
  localparam int QW = SQW + 3;
  localparam int DW = SQW + 6;
  localparam int SH = 2 * F - 5;
  localparam int QTW = 27;
  localparam longint unsigned WM_L =
    (64'd2071070 * (64'd1 << F) + 64'd5000000) / 64'd10000000;
  localparam logic [XW-1:0] WH = XW'(1) << (F - 1);
  localparam logic [XW-1:0] WM = XW'(WM_L);
  localparam logic [XW-1:0] WL = (XW'(1) << F) - WH - (WM << 1);
  // Reciprocal of seven, exact for quotients of 27-bit values.
  localparam logic [27:0] RECIP7 = 28'd153391690;

  logic en;
  logic va_r, vb_r, vc_r, vd_r, ve_r;
  lvv_pkg::meta_t ma_r, mb_r, mc_r, md_r, me_r;
  logic [XW-1:0]   x_nxt [8];
  logic [XW-1:0]   x_r [8];
  logic [SQW-1:0]  sq_r [8];
  logic [SUMW-1:0] s_nxt, s_r;
  logic [QW-1:0]   q_nxt, qsum_r;
  logic [DW-1:0]   ss_r, d_full;
  logic [QTW-1:0]  quo_r;
  logic [54:0]     prod_r;

  // The whole chain advances unless a result waits to be taken.
  assign en    = !out_s.valid || out_s.ready;
  assign q_pop = en && !q_empty;

  // Circle samples: axis pixels exact, diagonals interpolated.
  function automatic logic [XW-1:0] diag(input logic [7:0] d, input logic [7:0] a,
                                         input logic [7:0] b, input logic [7:0] c);
    logic [XW-1:0] ab;
    ab = XW'(a) + XW'(b);
    return (XW'(d) << (F - 1)) + WM * ab + WL * XW'(c);
  endfunction

  always_comb begin
    x_nxt[0] = XW'(job.win[5]) << F;
    x_nxt[1] = diag(job.win[2], job.win[1], job.win[5], job.win[4]);
    x_nxt[2] = XW'(job.win[1]) << F;
    x_nxt[3] = diag(job.win[0], job.win[1], job.win[3], job.win[4]);
    x_nxt[4] = XW'(job.win[3]) << F;
    x_nxt[5] = diag(job.win[6], job.win[3], job.win[7], job.win[4]);
    x_nxt[6] = XW'(job.win[7]) << F;
    x_nxt[7] = diag(job.win[8], job.win[5], job.win[7], job.win[4]);
  end

  // Sum of samples and sum of squares.
  always_comb begin
    s_nxt = '0;
    q_nxt = '0;
    for (int k = 0; k < 8; k++) begin
      s_nxt = s_nxt + SUMW'(x_r[k]);
      q_nxt = q_nxt + QW'(sq_r[k]);
    end
  end

  // Eight times the square sum minus the squared sum, with 2F fraction bits.
  assign d_full = {qsum_r, 3'b000} - ss_r;

  // Valid bits of each stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0; vb_r <= 1'b0; vc_r <= 1'b0; vd_r <= 1'b0; ve_r <= 1'b0;
      out_s.valid <= 1'b0;
    end else if (en) begin
      va_r <= !q_empty;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
      out_s.valid <= ve_r;
    end
  end

  // Datapath stages.
  always_ff @(posedge clk) begin
    if (en) begin
      x_r  <= x_nxt;
      ma_r <= job.meta;
      for (int k = 0; k < 8; k++) begin
        sq_r[k] <= x_r[k] * x_r[k];
      end
      s_r    <= s_nxt;
      mb_r   <= ma_r;
      qsum_r <= q_nxt;
      ss_r   <= DW'(s_r) * DW'(s_r);
      mc_r   <= mb_r;
      quo_r  <= d_full[SH+QTW-1:SH];
      md_r   <= mc_r;
      prod_r <= 55'(quo_r) * 55'(RECIP7);
      me_r   <= md_r;
      out_s.data.variance   <= prod_r[30+lvv_pkg::VAR_W-1:30];
      out_s.data.center_row <= me_r.row;
      out_s.data.center_col <= me_r.col;
      out_s.data.frame_end  <= me_r.frame_end;
    end
  end

`ifndef ASSERT_OFF
  a_stall_holds_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_s.valid && !out_s.ready) |=> $stable(ve_r) && $stable(prod_r))
    else $error("pipeline moved while the result was stalled");
  a_pop_only_when_moving: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> en)
    else $error("queue popped while the pipeline was stalled");
`endif
endmodule
`default_nettype wire
